FILE: src/menu_cursor_with_key_repeat_core_assert.svh
// ----------------------------------------------------------------------------
// Menu cursor assertion macros
// Shared concurrent assertion forms used by the menu cursor core modules.
// ----------------------------------------------------------------------------
`ifndef MENU_CURSOR_WITH_KEY_REPEAT_CORE_ASSERT_SVH
`define MENU_CURSOR_WITH_KEY_REPEAT_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Menu cursor package
// Payload types, key codes, register indexes and controller interface types.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int unsigned DataWidth = 8;
    localparam int unsigned DivWidth  = 2 * DataWidth;

    // Latched key codes, also used as the footer hint.
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_LEFT  = 2'd1;
    localparam logic [1:0] KEY_RIGHT = 2'd2;
    localparam logic [1:0] KEY_BACK  = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] REG_ITEM_COUNT   = 8'd0;
    localparam logic [7:0] REG_VISIBLE_ROWS = 8'd1;
    localparam logic [7:0] REG_FIRST_DELAY  = 8'd2;
    localparam logic [7:0] REG_REPEAT_DELAY = 8'd3;

    typedef struct packed {
        logic in_menu;
        logic key_left;
        logic key_right;
        logic key_back;
    } in_t;

    typedef struct packed {
        logic [7:0] cursor;
        logic [7:0] first_visible;
        logic       redraw;
        logic [1:0] highlight;
    } out_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic move;
        logic clamp;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic go_div;
        logic go_clamp;
        logic div_busy;
        logic move_clamp;
    } status_t;

endpackage

FILE: src/mcr_mod_unit.sv
// ----------------------------------------------------------------------------
// Menu cursor modulo unit
// Restoring shift-subtract remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mcr_mod_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mcr_pkg::DivWidth-1:0]    dividend,
    input  logic [mcr_pkg::DataWidth-1:0]   divisor,
    output logic                            busy,
    output logic [mcr_pkg::DataWidth-1:0]   remainder
);

    logic [mcr_pkg::DivWidth-1:0]  dvd_reg, dvd_next;
    logic [mcr_pkg::DataWidth-1:0] rem_reg, rem_next;
    logic [4:0]                    cnt_reg, cnt_next;
    logic [mcr_pkg::DataWidth:0]   trial;
    logic [mcr_pkg::DataWidth:0]   diff;

    assign trial = {rem_reg, dvd_reg[mcr_pkg::DivWidth-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = 5'(mcr_pkg::DivWidth);
        end else if (cnt_reg != 5'd0) begin
            dvd_next = {dvd_reg[mcr_pkg::DivWidth-2:0], 1'b0};
            // The partial remainder stays below the divisor, so the trial is
            // below twice the divisor and one subtraction suffices.
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[mcr_pkg::DataWidth-1:0];
            end else begin
                rem_next = trial[mcr_pkg::DataWidth-1:0];
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != 5'd0);
    assign remainder = rem_reg;

endmodule

FILE: src/mcr_datapath.sv
// ----------------------------------------------------------------------------
// Menu cursor datapath
// Configuration registers, key repeat state, cursor and scroll arithmetic.
// ----------------------------------------------------------------------------
module mcr_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_addr,
    input  logic [7:0]           cfg_data,
    input  mcr_pkg::in_t         in_data,
    input  mcr_pkg::cmd_t        cmd,
    output mcr_pkg::status_t     status,
    output mcr_pkg::out_t        out_data
);

    logic [7:0] item_count_reg, item_count_next;
    logic [7:0] visible_rows_reg, visible_rows_next;
    logic [7:0] first_delay_reg, first_delay_next;
    logic [7:0] repeat_delay_reg, repeat_delay_next;

    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] scroll_reg, scroll_next;
    logic [1:0] held_key_reg, held_key_next;
    logic [7:0] delay_count_reg, delay_count_next;
    logic       redraw_reg, redraw_next;
    logic [1:0] hint_reg, hint_next;

    mcr_pkg::in_t  in_reg, in_next;
    mcr_pkg::out_t out_reg, out_next;

    logic        still;
    logic        act;
    logic [7:0]  left_nxt;
    logic        left_moves;
    logic        div_start;
    logic        div_busy;
    logic [15:0] dividend;
    logic [7:0]  rem;
    logic        move_takes;

    logic [7:0]  s1;
    logic [8:0]  s1_plus_rows;
    logic [7:0]  s2;
    logic [7:0]  total_minus_rows;
    logic [7:0]  s3;

    // A repeat action fires in the menu when the latched key is still held, its
    // countdown has run out and the item count is not zero.
    assign still = (held_key_reg == mcr_pkg::KEY_LEFT  && in_reg.key_left)  ||
                   (held_key_reg == mcr_pkg::KEY_RIGHT && in_reg.key_right) ||
                   (held_key_reg == mcr_pkg::KEY_BACK  && in_reg.key_back);
    assign act = in_reg.in_menu && still && (delay_count_reg == 8'd0) &&
                 (item_count_reg != 8'd0);

    assign left_nxt   = (cursor_reg == 8'd0) ? item_count_reg - 8'd1 : cursor_reg - 8'd1;
    assign left_moves = (left_nxt != cursor_reg);

    assign div_start = cmd.eval && status.go_div;
    // Back step: (cursor - rows) mod count, lifted by count * 256 so it never
    // goes negative.
    assign dividend = (held_key_reg == mcr_pkg::KEY_BACK)
                    ? ({item_count_reg, 8'd0} + {8'd0, cursor_reg} - {8'd0, visible_rows_reg})
                    : ({8'd0, cursor_reg} + 16'd1);

    mcr_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (item_count_reg),
        .busy      (div_busy),
        .remainder (rem)
    );

    assign move_takes = (held_key_reg == mcr_pkg::KEY_BACK) || (rem != cursor_reg);

    assign status.go_div     = act && (held_key_reg != mcr_pkg::KEY_LEFT);
    assign status.go_clamp   = act && (held_key_reg == mcr_pkg::KEY_LEFT) && left_moves;
    assign status.div_busy   = div_busy;
    assign status.move_clamp = move_takes;

    // Scroll clamp on the updated cursor.
    assign s1               = (cursor_reg < scroll_reg) ? cursor_reg : scroll_reg;
    assign s1_plus_rows     = {1'b0, s1} + {1'b0, visible_rows_reg};
    assign s2               = ({1'b0, cursor_reg} >= s1_plus_rows)
                            ? cursor_reg + 8'd1 - visible_rows_reg : s1;
    assign total_minus_rows = item_count_reg - visible_rows_reg;
    assign s3               = ((item_count_reg > visible_rows_reg) && (s2 > total_minus_rows))
                            ? total_minus_rows : s2;

    always_comb begin
        item_count_next   = item_count_reg;
        visible_rows_next = visible_rows_reg;
        first_delay_next  = first_delay_reg;
        repeat_delay_next = repeat_delay_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                mcr_pkg::REG_ITEM_COUNT:   item_count_next   = cfg_data;
                mcr_pkg::REG_VISIBLE_ROWS: visible_rows_next = cfg_data;
                mcr_pkg::REG_FIRST_DELAY:  first_delay_next  = cfg_data;
                mcr_pkg::REG_REPEAT_DELAY: repeat_delay_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_next          = in_reg;
        cursor_next      = cursor_reg;
        scroll_next      = scroll_reg;
        held_key_next    = held_key_reg;
        delay_count_next = delay_count_reg;
        redraw_next      = redraw_reg;
        hint_next        = hint_reg;
        out_next         = out_reg;

        if (cmd.capture) begin
            in_next = in_data;
        end

        if (cmd.eval) begin
            redraw_next = 1'b0;
            hint_next   = mcr_pkg::KEY_NONE;
            if (!in_reg.in_menu) begin
                held_key_next    = mcr_pkg::KEY_NONE;
                delay_count_next = 8'd0;
            end else if (!still) begin
                delay_count_next = first_delay_reg;
                if (in_reg.key_left) begin
                    held_key_next = mcr_pkg::KEY_LEFT;
                end else if (in_reg.key_right) begin
                    held_key_next = mcr_pkg::KEY_RIGHT;
                end else if (in_reg.key_back) begin
                    held_key_next = mcr_pkg::KEY_BACK;
                end else begin
                    held_key_next    = mcr_pkg::KEY_NONE;
                    delay_count_next = 8'd0;
                end
            end else if (delay_count_reg != 8'd0) begin
                delay_count_next = delay_count_reg - 8'd1;
            end else begin
                delay_count_next = repeat_delay_reg;
                if (status.go_clamp) begin
                    cursor_next = left_nxt;
                    redraw_next = 1'b1;
                    hint_next   = mcr_pkg::KEY_LEFT;
                end
            end
        end

        if (cmd.move && move_takes) begin
            cursor_next = rem;
            redraw_next = 1'b1;
            hint_next   = held_key_reg;
        end

        if (cmd.clamp) begin
            scroll_next = s3;
        end

        if (cmd.out_load) begin
            out_next.cursor        = cursor_reg;
            out_next.first_visible = scroll_reg;
            out_next.redraw        = redraw_reg;
            out_next.highlight     = hint_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg   <= 8'd0;
            visible_rows_reg <= 8'd4;
            first_delay_reg  <= 8'd20;
            repeat_delay_reg <= 8'd5;
            cursor_reg       <= 8'd0;
            scroll_reg       <= 8'd0;
            held_key_reg     <= mcr_pkg::KEY_NONE;
            delay_count_reg  <= 8'd0;
            redraw_reg       <= 1'b0;
            hint_reg         <= mcr_pkg::KEY_NONE;
        end else begin
            item_count_reg   <= item_count_next;
            visible_rows_reg <= visible_rows_next;
            first_delay_reg  <= first_delay_next;
            repeat_delay_reg <= repeat_delay_next;
            cursor_reg       <= cursor_next;
            scroll_reg       <= scroll_next;
            held_key_reg     <= held_key_next;
            delay_count_reg  <= delay_count_next;
            redraw_reg       <= redraw_next;
            hint_reg         <= hint_next;
        end
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

FILE: src/mcr_controller.sv
// ----------------------------------------------------------------------------
// Menu cursor controller
// Sequences one tick through evaluation, modulo, move and scroll clamp.
// ----------------------------------------------------------------------------
module mcr_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  mcr_pkg::status_t     status,
    output mcr_pkg::cmd_t        cmd
);

`include "menu_cursor_with_key_repeat_core_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.go_div) begin
                    state_next = ST_DIV;
                end else if (status.go_clamp) begin
                    state_next = ST_CLAMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                cmd.move   = 1'b1;
                state_next = status.move_clamp ? ST_CLAMP : ST_DONE;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // The previous result may still be waiting; hold until it goes.
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `MCR_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready,
        "result register overwritten before the transaction completed")
    `MCR_ASSERT_NEXT(a_div_started, (state_reg == ST_EVAL) && status.go_div,
        status.div_busy, "modulo unit did not start")
    `MCR_ASSERT_NOW(a_move_after_div, state_reg == ST_MOVE, !status.div_busy,
        "move taken while the modulo unit is still running")

endmodule

FILE: src/menu_cursor_with_key_repeat_core.sv
// ----------------------------------------------------------------------------
// Menu cursor with key repeat core
// Typematic key repeat driving a wrapping menu cursor and scroll offset.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    mcr_pkg::in_t  (one tick)
//  m_        out        m_valid / m_ready    mcr_pkg::out_t (one result per tick)
//  cfg_      in         cfg_valid/cfg_ready  cfg_addr (index), cfg_data
//
//  A result passes evaluation, then for a back or right step the bit-serial
//  modulo unit and a move, and a scroll clamp after a back step or after a left
//  or right step that moves the cursor; s_ready returns with the result.
//  Reset is synchronous and active low; configuration returns to 0, 4, 20, 5.
//  A stalled result holds in the output register while the next transaction
//  is accepted; that tick then waits in the core before loading its result.
// ----------------------------------------------------------------------------
module menu_cursor_with_key_repeat_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mcr_pkg::in_t     s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mcr_pkg::out_t    m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_addr,
    input  logic [7:0]       cfg_data
);

    mcr_pkg::cmd_t    cmd;
    mcr_pkg::status_t status;
    logic             cfg_we;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    mcr_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcr_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_data  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_data)
    );

endmodule

FILE: test/menu_cursor_with_key_repeat_core_tb.sv
// ----------------------------------------------------------------------------
// Menu cursor with key repeat testbench
// Drives button ticks and register writes into the core. A cycle-free model
// of the typematic repeat, cursor wrap and scroll clamp predicts each result,
// and every result transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module menu_cursor_with_key_repeat_core_tb;

    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned StallLimit  = 4000;

    logic          aclk;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    mcr_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    mcr_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_addr  = '0;
    logic [7:0]    cfg_data  = '0;

    // Predicted register settings and block state.
    logic [7:0] num_items;
    logic [7:0] num_rows;
    logic [7:0] delay_first;
    logic [7:0] delay_repeat;
    logic [7:0] sel_row;
    logic [7:0] view_top;
    logic [1:0] latched_key;
    logic [7:0] repeat_count;

    mcr_pkg::out_t expected_views[$];
    int unsigned   errors       = 0;
    int unsigned   quiet_cycles = 0;
    logic          steady       = 1'b0;
    logic          hold_results = 1'b0;

    menu_cursor_with_key_repeat_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Keeps the cursor row inside the visible window.
    function automatic void clamp_view();
        int unsigned total;
        int unsigned rows;
        int unsigned cur;
        total = num_items;
        rows  = num_rows;
        cur   = sel_row;
        if (cur < view_top) view_top = sel_row;
        if (cur >= view_top + rows) view_top = 8'(cur + 1 - rows);
        if (total > rows && view_top > total - rows) view_top = 8'(total - rows);
    endfunction

    function automatic mcr_pkg::out_t advance_menu(input mcr_pkg::in_t t);
        logic          still;
        logic          moved;
        logic [1:0]    hint;
        int unsigned   total;
        int unsigned   cur;
        int unsigned   nxt;
        mcr_pkg::out_t r;
        moved = 1'b0;
        hint  = mcr_pkg::KEY_NONE;
        total = num_items;
        cur   = sel_row;
        if (!t.in_menu) begin
            latched_key  = mcr_pkg::KEY_NONE;
            repeat_count = '0;
        end else begin
            still = (latched_key == mcr_pkg::KEY_LEFT && t.key_left) ||
                    (latched_key == mcr_pkg::KEY_RIGHT && t.key_right) ||
                    (latched_key == mcr_pkg::KEY_BACK && t.key_back);
            if (!still) begin
                repeat_count = delay_first;
                if (t.key_left) latched_key = mcr_pkg::KEY_LEFT;
                else if (t.key_right) latched_key = mcr_pkg::KEY_RIGHT;
                else if (t.key_back) latched_key = mcr_pkg::KEY_BACK;
                else begin
                    latched_key  = mcr_pkg::KEY_NONE;
                    repeat_count = '0;
                end
            end else if (repeat_count != 0) begin
                repeat_count = repeat_count - 8'd1;
            end else begin
                if (total != 0) begin
                    if (latched_key == mcr_pkg::KEY_BACK) begin
                        nxt = (cur + total * 256 - num_rows) % total;
                        sel_row = 8'(nxt);
                        clamp_view();
                        moved = 1'b1;
                        hint  = mcr_pkg::KEY_BACK;
                    end else begin
                        if (latched_key == mcr_pkg::KEY_LEFT) nxt = (cur == 0) ? total - 1 : cur - 1;
                        else nxt = (cur + 1) % total;
                        // A one-item menu gives no visible step.
                        if (nxt != cur) begin
                            sel_row = 8'(nxt);
                            clamp_view();
                            moved = 1'b1;
                            hint  = latched_key;
                        end
                    end
                end
                repeat_count = delay_repeat;
            end
        end
        r.cursor        = sel_row;
        r.first_visible = view_top;
        r.redraw        = moved;
        r.highlight     = hint;
        return r;
    endfunction

    task automatic send_tick(input mcr_pkg::in_t t);
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_views.push_back(advance_menu(t));
        if (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic press(input logic menu, input logic l, input logic r, input logic b,
                         input int unsigned ticks);
        mcr_pkg::in_t t;
        t.in_menu   = menu;
        t.key_left  = l;
        t.key_right = r;
        t.key_back  = b;
        repeat (ticks) send_tick(t);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            mcr_pkg::REG_ITEM_COUNT:   num_items    = value;
            mcr_pkg::REG_VISIBLE_ROWS: num_rows     = value;
            mcr_pkg::REG_FIRST_DELAY:  delay_first  = value;
            mcr_pkg::REG_REPEAT_DELAY: delay_repeat = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] items, input logic [7:0] rows,
                              input logic [7:0] first_d, input logic [7:0] repeat_d);
        write_reg(mcr_pkg::REG_ITEM_COUNT, items);
        write_reg(mcr_pkg::REG_VISIBLE_ROWS, rows);
        write_reg(mcr_pkg::REG_FIRST_DELAY, first_d);
        write_reg(mcr_pkg::REG_REPEAT_DELAY, repeat_d);
        cfg_valid <= 1'b0;
    endtask

    // Mostly one key held for a while and then released, with some raw noise.
    task automatic run_bursts(input int unsigned count);
        int unsigned  sent;
        int unsigned  len;
        logic [1:0]   key;
        mcr_pkg::in_t t;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 75) begin
                key = 2'($urandom_range(1, 3));
                len = $urandom_range(1, 14);
                for (int k = 0; k < len; k++) begin
                    t.in_menu   = 1'b1;
                    t.key_left  = (key == mcr_pkg::KEY_LEFT);
                    t.key_right = (key == mcr_pkg::KEY_RIGHT);
                    t.key_back  = (key == mcr_pkg::KEY_BACK);
                    if (k > 0 && $urandom_range(0, 99) < 15)
                        t = mcr_pkg::in_t'(t | 4'($urandom_range(0, 7)));
                    send_tick(t);
                    sent++;
                end
                if ($urandom_range(0, 99) < 60) begin
                    press(1'b1, 1'b0, 1'b0, 1'b0, 1);
                    sent++;
                end
            end else begin
                send_tick(mcr_pkg::in_t'(4'($urandom_range(0, 15))));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] items, input logic [7:0] rows,
                             input logic [7:0] first_d, input logic [7:0] repeat_d,
                             input int unsigned count);
        set_config(items, rows, first_d, repeat_d);
        run_bursts(count);
        wait_for_results();
    endtask

    task automatic test_reset_config();
        // Default settings have no items, so held keys must not move anything.
        press(1'b1, 1'b1, 1'b0, 1'b0, 3);
        press(1'b0, 1'b0, 1'b0, 1'b0, 1);
        wait_for_results();
    endtask

    task automatic test_key_actions();
        set_config(8'd5, 8'd2, 8'd0, 8'd0);
        press(1'b1, 1'b1, 1'b0, 1'b0, 3);
        press(1'b1, 1'b0, 1'b0, 1'b0, 1);
        press(1'b1, 1'b0, 1'b1, 1'b0, 2);
        press(1'b1, 1'b0, 1'b0, 1'b1, 2);
        // Higher priority keys are ignored while back stays latched.
        press(1'b1, 1'b1, 1'b1, 1'b1, 2);
        press(1'b0, 1'b1, 1'b0, 1'b0, 1);
        wait_for_results();
    endtask

    task automatic test_edge_sizes();
        set_config(8'd1, 8'd1, 8'd0, 8'd0);
        press(1'b1, 1'b0, 1'b1, 1'b0, 2);
        press(1'b1, 1'b0, 1'b0, 1'b1, 2);
        wait_for_results();
        set_config(8'd0, 8'd4, 8'd0, 8'd0);
        press(1'b1, 1'b1, 1'b0, 1'b0, 2);
        wait_for_results();
        set_config(8'd9, 8'd0, 8'd0, 8'd0);
        press(1'b1, 1'b0, 1'b0, 1'b1, 2);
        wait_for_results();
    endtask

    task automatic test_shrunk_count();
        // Park the cursor far down, then shrink the menu under it.
        set_config(8'd200, 8'd60, 8'd0, 8'd0);
        press(1'b1, 1'b0, 1'b0, 1'b1, 2);
        wait_for_results();
        set_config(8'd10, 8'd3, 8'd0, 8'd0);
        press(1'b1, 1'b1, 1'b0, 1'b0, 2);
        wait_for_results();
        set_config(8'd200, 8'd60, 8'd0, 8'd0);
        press(1'b1, 1'b0, 1'b0, 1'b1, 2);
        wait_for_results();
        set_config(8'd10, 8'd3, 8'd0, 8'd0);
        press(1'b1, 1'b0, 1'b0, 1'b1, 1);
        wait_for_results();
    endtask

    task automatic test_random_settings();
        run_phase(8'd12, 8'd3, 8'd2, 8'd1, 90);
        run_phase(8'd255, 8'd1, 8'd0, 8'd0, 90);
        run_phase(8'd7, 8'd255, 8'd1, 8'd0, 90);
        run_phase(8'd200, 8'd17, 8'd0, 8'd2, 90);
        run_phase(8'd0, 8'd0, 8'd3, 8'd3, 90);
        run_phase(8'd1, 8'd1, 8'd0, 8'd0, 90);
        run_phase(8'd170, 8'd85, 8'd0, 8'd1, 90);
        run_phase(8'd85, 8'd170, 8'd255, 8'd255, 90);
        run_phase(8'd33, 8'd0, 8'd0, 8'd0, 90);
    endtask

    task automatic test_random_config();
        repeat (2) begin
            run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)), 80);
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_phase(8'd40, 8'd6, 8'd1, 8'd0, 150);
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        set_config(8'd20, 8'd4, 8'd0, 8'd0);
        hold_results = 1'b1;
        press(1'b1, 1'b0, 1'b1, 1'b0, 30);
        wait_for_results();
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        mcr_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_views.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, m_data);
            end else begin
                want = expected_views.pop_front();
                if (m_data.cursor !== want.cursor)
                    report_mismatch("cursor", want.cursor, m_data.cursor);
                if (m_data.first_visible !== want.first_visible)
                    report_mismatch("first_visible", want.first_visible, m_data.first_visible);
                if (m_data.redraw !== want.redraw)
                    report_mismatch("redraw", want.redraw, m_data.redraw);
                if (m_data.highlight !== want.highlight)
                    report_mismatch("highlight", want.highlight, m_data.highlight);
            end
        end
    end

    // Result side: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        num_items    = 8'd0;
        num_rows     = 8'd4;
        delay_first  = 8'd20;
        delay_repeat = 8'd5;
        sel_row      = '0;
        view_top     = '0;
        latched_key  = mcr_pkg::KEY_NONE;
        repeat_count = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_key_actions();
        test_edge_sizes();
        test_shrunk_count();
        test_backpressure();
        test_steady_stream();
        test_random_settings();
        test_random_config();

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_views.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/mcr_pkg.sv
src/mcr_mod_unit.sv
src/mcr_datapath.sv
src/mcr_controller.sv
src/menu_cursor_with_key_repeat_core.sv
test/menu_cursor_with_key_repeat_core_tb.sv
